// ----- rtl/scoped_local_slot_stack_core_macros.svh -----
// Assertion macros used by the slot stack core.
`ifndef SCOPED_LOCAL_SLOT_STACK_CORE_MACROS_SVH
`define SCOPED_LOCAL_SLOT_STACK_CORE_MACROS_SVH

// Checked at every clock edge outside reset.
`define SLSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SLSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/slss_pkg.sv -----
// ----------------------------------------------------------------------------
// slss_pkg
// Types and codes of the scoped local slot stack.
// ----------------------------------------------------------------------------
package slss_pkg;

  typedef enum logic [2:0] {
    FN_ENTER_BODY  = 3'd0,
    FN_LEAVE_BODY  = 3'd1,
    FN_ENTER_BLOCK = 3'd2,
    FN_LEAVE_BLOCK = 3'd3,
    FN_PUSH        = 3'd4,
    FN_FIND        = 3'd5,
    FN_POP_N       = 3'd6,
    FN_NOP         = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REDECLARED = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_t;

  typedef enum logic [1:0] {
    SM_FIND,
    SM_CHECK,
    SM_POP
  } scan_mode_t;

  // Count field is wide enough for stack depths up to 2047.
  localparam int CNT_W = 11;
  localparam int POS_W = 9;

  typedef struct packed {
    logic             valid;
    scan_mode_t       mode;
    logic             hit;
    logic             stop;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] pos;
  } token_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] name_key;
    logic [6:0]  amount;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [8:0]  position;
    logic [6:0]  number;
    logic [6:0]  depth;
    logic [7:0]  level;
  } out_item_t;

endpackage

// ----- rtl/scoped_local_slot_stack_core.sv -----
// Results: enter/leave body, enter block, pop n and no-op give their result in the
// cycle after the transfer; push, find and leave block give theirs once the search
// token, walking the cell chain one cell per cycle, has passed the last cell.
// One item is in work at a time; the next is taken once the result is transferred.
// Reset: depth, peak, level, slot base and handshake state clear; entries are
// undefined until pushed.
// ----------------------------------------------------------------------------
// scoped_local_slot_stack_core
// Scoped stack of local-variable slots built as a chain of entry cells.
// ----------------------------------------------------------------------------
module scoped_local_slot_stack_core #(
  parameter int STACK_DEPTH = 64,
  parameter int KEY_WIDTH   = 16,
  parameter int MAX_NEST    = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  slss_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slss_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import slss_pkg::*;
  `include "scoped_local_slot_stack_core_macros.svh"

  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int LVL_W = $clog2(MAX_NEST + 1);

  fsm_t              state_r, state_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [DW-1:0]     peak_r, peak_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [7:0]        base_r;
  func_t             func_r, func_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic              inject_r, inject_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              accept;
  logic              wr_en;
  logic [POS_W-1:0]  push_pos;
  logic [DW-1:0]     pop_cnt;
  token_t            tok [0:STACK_DEPTH];
  token_t            tok_start;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != FSM_IDLE) || out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign push_pos  = POS_W'(depth_r) + POS_W'(base_r);
  assign pop_cnt   = DW'(tok[0].cnt);

  always_comb begin
    tok_start       = '0;
    tok_start.valid = inject_r;
    case (func_r)
      FN_PUSH:        tok_start.mode = SM_CHECK;
      FN_LEAVE_BLOCK: tok_start.mode = SM_POP;
      default:        tok_start.mode = SM_FIND;
    endcase
  end
  assign tok[STACK_DEPTH] = tok_start;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      slss_cell #(
        .KEY_W (KEY_WIDTH),
        .LVL_W (LVL_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .occupied (DW'(gi) < depth_r),
        .wr_en    (wr_en && depth_r == DW'(gi)),
        .wr_key   (key_r),
        .wr_level (level_r),
        .wr_pos   (push_pos),
        .q_key    (key_r),
        .q_level  (level_r),
        .tok_in   (tok[gi+1]),
        .tok_out  (tok[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    peak_nxt      = peak_r;
    level_nxt     = level_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    inject_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    wr_en         = 1'b0;

    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          func_nxt     = in_data.func;
          key_nxt      = KEY_WIDTH'(in_data.name_key);
          out_nxt      = '0;
          case (in_data.func)
            FN_ENTER_BODY: begin
              depth_nxt = '0;
              peak_nxt  = '0;
              level_nxt = '0;
            end
            FN_LEAVE_BODY: begin
              out_nxt.number = 7'(peak_r);
              depth_nxt = '0;
              peak_nxt  = '0;
              level_nxt = '0;
            end
            FN_ENTER_BLOCK: begin
              if (level_r < LVL_W'(MAX_NEST)) level_nxt = level_r + 1'b1;
            end
            FN_POP_N: begin
              if (int'(in_data.amount) < int'(depth_r)) begin
                out_nxt.number = in_data.amount;
                depth_nxt      = depth_r - DW'(in_data.amount);
              end else begin
                out_nxt.number = 7'(depth_r);
                depth_nxt      = '0;
              end
            end
            FN_LEAVE_BLOCK, FN_PUSH, FN_FIND: begin
              state_nxt  = FSM_SCAN;
              inject_nxt = 1'b1;
            end
            default: ;
          endcase
          if (state_nxt == FSM_IDLE) begin
            out_valid_nxt = 1'b1;
            out_nxt.depth = 7'(depth_nxt);
            out_nxt.level = 8'(level_nxt);
          end
        end
      end
      FSM_SCAN: begin
        if (tok[0].valid) begin
          state_nxt = FSM_IDLE;
          case (func_r)
            FN_LEAVE_BLOCK: begin
              out_nxt.number = 7'(pop_cnt);
              depth_nxt      = depth_r - pop_cnt;
              if (level_r != '0) level_nxt = level_r - 1'b1;
            end
            FN_PUSH: begin
              if (tok[0].hit) begin
                out_nxt.status = ST_REDECLARED;
              end else if (depth_r >= DW'(STACK_DEPTH)) begin
                out_nxt.status = ST_FULL;
              end else begin
                wr_en            = 1'b1;
                out_nxt.position = push_pos;
                depth_nxt        = depth_r + 1'b1;
                if (depth_nxt > peak_r) peak_nxt = depth_nxt;
              end
            end
            FN_FIND: begin
              if (tok[0].hit) out_nxt.position = tok[0].pos;
              else            out_nxt.status   = ST_NOT_FOUND;
            end
            default: ;
          endcase
          out_valid_nxt = 1'b1;
          out_nxt.depth = 7'(depth_nxt);
          out_nxt.level = 8'(level_nxt);
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      depth_r     <= '0;
      peak_r      <= '0;
      level_r     <= '0;
      base_r      <= '0;
      inject_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      peak_r      <= peak_nxt;
      level_r     <= level_nxt;
      inject_r    <= inject_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) base_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    key_r  <= key_nxt;
    out_r  <= out_nxt;
  end

  `SLSS_ASSERT(a_depth_bound, depth_r <= DW'(STACK_DEPTH), "stack depth beyond capacity")
  `SLSS_ASSERT(a_peak_ge_depth, peak_r >= depth_r, "peak depth below current depth")
  `SLSS_ASSERT(a_token_in_scan, tok[0].valid |-> state_r == FSM_SCAN, "token left chain outside scan")
  `SLSS_ASSERT(a_out_idle, out_valid_r |-> state_r == FSM_IDLE, "result pending while scanning")
  `SLSS_ASSERT_ALWAYS(a_no_accept_busy, (state_r == FSM_SCAN) |-> in_stall, "input taken during scan")

endmodule

// ----- rtl/slss_cell.sv -----
// ----------------------------------------------------------------------------
// slss_cell
// One stack entry plus one stage of the search token that walks the chain.
// ----------------------------------------------------------------------------
module slss_cell #(
  parameter int KEY_W = 16,
  parameter int LVL_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  occupied,
  input  logic                  wr_en,
  input  logic [KEY_W-1:0]      wr_key,
  input  logic [LVL_W-1:0]      wr_level,
  input  logic [slss_pkg::POS_W-1:0] wr_pos,
  input  logic [KEY_W-1:0]      q_key,
  input  logic [LVL_W-1:0]      q_level,
  input  slss_pkg::token_t      tok_in,
  output slss_pkg::token_t      tok_out
);
  import slss_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [LVL_W-1:0] level_r;
  logic [POS_W-1:0] pos_r;
  token_t           tok_r;
  token_t           tok_nxt;
  logic             lvl_eq;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r   <= wr_key;
      level_r <= wr_level;
      pos_r   <= wr_pos;
    end
  end

  assign lvl_eq = (level_r == q_level);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && occupied) begin
      case (tok_in.mode)
        SM_FIND, SM_CHECK: begin
          // The token runs from the top down, so the first hit is the newest.
          if (!tok_in.hit && key_r == q_key && (tok_in.mode == SM_FIND || lvl_eq)) begin
            tok_nxt.hit = 1'b1;
            tok_nxt.pos = pos_r;
          end
        end
        SM_POP: begin
          if (!tok_in.stop) begin
            if (lvl_eq) tok_nxt.cnt = tok_in.cnt + 1'b1;
            else        tok_nxt.stop = 1'b1;
          end
        end
        default: tok_nxt = tok_in;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
